### rtl/ddfd_pkg.sv
// Shared widths, constants and the command type of the decimal display frame driver.
package ddfd_pkg;

	localparam int VALUE_W     = 27;
	localparam int ADDR_W      = 4;
	localparam int CODE_W      = 4;
	localparam int COUNT_W     = 4;
	localparam int MAX_DIGITS  = 8;
	localparam int DIGITS_DEF  = 8;
	localparam int QUEUE_DEF   = 2;

	localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;

	typedef struct packed {
		logic [MAX_DIGITS-1:0][CODE_W-1:0] bcd;
		logic [COUNT_W-1:0]                ndig;
		logic                              blank;
	} cmd_t;

endpackage

### rtl/ddfd_if.sv
// Valid/ready channel interfaces for input values and display frames.
interface ddfd_value_if;
	logic                         valid;
	logic                         ready;
	logic [ddfd_pkg::VALUE_W-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface ddfd_frame_if;
	logic                        valid;
	logic                        ready;
	logic [ddfd_pkg::ADDR_W-1:0] digit_address;
	logic [ddfd_pkg::CODE_W-1:0] digit_code;
	logic                        last_frame;

	modport source(output valid, output digit_address, output digit_code, output last_frame,
		input ready);
	modport sink(input valid, input digit_address, input digit_code, input last_frame,
		output ready);
endinterface

### rtl/ddfd_front.sv
// Front end: accepts a value, converts it to BCD one bit per cycle and classifies it.
module ddfd_front #(
	parameter int DIGITS = ddfd_pkg::DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ddfd_value_if.sink           values,
	output logic                 push,
	output ddfd_pkg::cmd_t       cmd,
	input  logic                 full
);

	localparam int BCD_W = DIGITS * ddfd_pkg::CODE_W;
	localparam int SH_W  = BCD_W + ddfd_pkg::VALUE_W;
	localparam int CNT_W = $clog2(ddfd_pkg::VALUE_W);
	localparam logic [ddfd_pkg::VALUE_W-1:0] LIMIT = ddfd_pkg::VALUE_W'(10 ** DIGITS - 1);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(ddfd_pkg::VALUE_W - 1);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t                                   state_q;
	logic [ddfd_pkg::VALUE_W-1:0]              bin_q;
	logic [DIGITS-1:0][ddfd_pkg::CODE_W-1:0]   bcd_q;
	logic [CNT_W-1:0]                          cnt_q;
	logic [ddfd_pkg::COUNT_W-1:0]              lit_q;

	logic [DIGITS-1:0][ddfd_pkg::CODE_W-1:0]   adj;
	logic [SH_W-1:0]                           sh;
	logic [ddfd_pkg::COUNT_W-1:0]              ndig;
	logic                                      accept;

	assign values.ready = (state_q == F_IDLE);
	assign accept       = values.valid && values.ready;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		sh = {adj, bin_q} << 1;
	end

	// Zero counts as one digit, so the count starts at one.
	always_comb begin
		ndig = ddfd_pkg::COUNT_W'(1);
		for (int i = 1; i < DIGITS; i++) begin
			if (bcd_q[i] != '0) begin
				ndig = ddfd_pkg::COUNT_W'(i + 1);
			end
		end
	end

	always_comb begin
		cmd.bcd = '0;
		for (int i = 0; i < DIGITS; i++) begin
			cmd.bcd[i] = bcd_q[i];
		end
		cmd.ndig  = ndig;
		cmd.blank = (ndig < lit_q);
	end

	assign push = (state_q == F_PUSH) && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			lit_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_CONV;
					end
				end
				F_CONV: begin
					if (cnt_q == LAST_BIT) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						lit_q   <= ndig;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= (values.value > LIMIT) ? LIMIT : values.value;
			bcd_q <= '0;
			cnt_q <= '0;
		end else if (state_q == F_CONV) begin
			bcd_q <= sh[SH_W-1:ddfd_pkg::VALUE_W];
			bin_q <= sh[ddfd_pkg::VALUE_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

### rtl/ddfd_queue.sv
// Small command queue between the front end and the frame sequencer.
module ddfd_queue #(
	parameter int DEPTH = ddfd_pkg::QUEUE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ddfd_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output ddfd_pkg::cmd_t rdata,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	ddfd_pkg::cmd_t  mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/ddfd_back.sv
// Back end: turns one command into blanking and digit frames, one beat per ready cycle.
module ddfd_back #(
	parameter int DIGITS = ddfd_pkg::DIGITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  ddfd_pkg::cmd_t cmd,
	output logic           pop,
	ddfd_frame_if.source   frames
);

	localparam int IDX_W = $clog2(ddfd_pkg::MAX_DIGITS);
	localparam logic [ddfd_pkg::ADDR_W-1:0] TOP_POS = ddfd_pkg::ADDR_W'(DIGITS);

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_BLANK = 3'b010,
		B_DIGIT = 3'b100
	} bstate_t;

	bstate_t                                            state_q;
	logic [ddfd_pkg::MAX_DIGITS-1:0][ddfd_pkg::CODE_W-1:0] bcd_q;
	logic [ddfd_pkg::COUNT_W-1:0]                       ndig_q;
	logic [ddfd_pkg::ADDR_W-1:0]                        pos_q;
	logic                                               valid_q;
	logic [ddfd_pkg::ADDR_W-1:0]                        addr_q;
	logic [ddfd_pkg::CODE_W-1:0]                        code_q;
	logic                                               last_q;

	logic                                               can_load;
	logic                                               emit;
	logic [IDX_W-1:0]                                   idx;

	assign can_load = !valid_q || frames.ready;
	assign emit     = can_load && (state_q != B_IDLE);
	assign pop      = (state_q == B_IDLE) && !empty;
	assign idx      = IDX_W'(pos_q - 1'b1);

	assign frames.valid         = valid_q;
	assign frames.digit_address = addr_q;
	assign frames.digit_code    = code_q;
	assign frames.last_frame    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (can_load) begin
				valid_q <= emit;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						state_q <= cmd.blank ? B_BLANK : B_DIGIT;
					end
				end
				B_BLANK: begin
					if (can_load && pos_q == TOP_POS) begin
						state_q <= B_DIGIT;
					end
				end
				B_DIGIT: begin
					if (can_load && pos_q == ddfd_pkg::ADDR_W'(1)) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bcd_q  <= cmd.bcd;
			ndig_q <= cmd.ndig;
			pos_q  <= cmd.blank ? ddfd_pkg::ADDR_W'(1) : ddfd_pkg::ADDR_W'(cmd.ndig);
		end else if (emit) begin
			addr_q <= pos_q;
			if (state_q == B_BLANK) begin
				code_q <= ddfd_pkg::BLANK_CODE;
				last_q <= 1'b0;
				pos_q  <= (pos_q == TOP_POS) ? ddfd_pkg::ADDR_W'(ndig_q) : pos_q + 1'b1;
			end else begin
				code_q <= bcd_q[idx];
				last_q <= (pos_q == ddfd_pkg::ADDR_W'(1));
				pos_q  <= pos_q - 1'b1;
			end
		end
	end

endmodule

### rtl/decimal_display_frame_driver_top.sv
// Top level of the decimal display frame driver.
// Each accepted value is clamped to DIGITS decimal digits, converted to BCD by a
// shift-and-add-3 unit that takes one input bit per cycle, and then sent out as
// display frames from a registered output, one frame per cycle while the sink is
// ready: DIGITS blanking frames first when the new value has fewer digits than
// the one shown before, then one frame per digit from the most significant
// position down to position 1, the last of them marked with last_frame. The
// converter takes a new value only when idle, after the value beat, the shift
// steps and the hand-over of the command to the queue, which waits while the
// queue is full. The frame sequencer fetches a command from the queue and then
// sends its frames, and a command queue of QUEUE_DEPTH entries (two by default)
// lets the converter work on the next value while frames of the previous one
// are still going out, so the converter sets the pace unless the sink holds
// frames back.
module decimal_display_frame_driver_top #(
	parameter int DIGITS      = ddfd_pkg::DIGITS_DEF,
	parameter int QUEUE_DEPTH = ddfd_pkg::QUEUE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ddfd_value_if.sink   values,
	ddfd_frame_if.source frames
);

	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	ddfd_pkg::cmd_t wcmd;
	ddfd_pkg::cmd_t rcmd;

	ddfd_front #(.DIGITS(DIGITS)) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.values(values),
		.push  (push),
		.cmd   (wcmd),
		.full  (full)
	);

	ddfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wcmd),
		.full  (full),
		.pop   (pop),
		.rdata (rcmd),
		.empty (empty)
	);

	ddfd_back #(.DIGITS(DIGITS)) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.empty (empty),
		.cmd   (rcmd),
		.pop   (pop),
		.frames(frames)
	);

endmodule
